[hw/rtl/text_console_cursor_engine_core_macros.svh]
// Assertion macros for the text console cursor engine.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define TCCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcce_pkg.sv]
// Shared types and constants of the text console cursor engine.
// No dependencies; used by the channel interfaces and the top level.
package tcce_pkg;

  // Field and state widths.
  localparam int unsigned CodeW   = 8;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned PosW    = 13;
  localparam int unsigned SpanW   = 14;
  localparam int unsigned CellW   = 6;
  localparam int unsigned CountW  = 8;
  localparam int unsigned FontXW  = 8;
  localparam int unsigned FontYW  = 10;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // A tab advances by eight cells, a shift by three.
  localparam int unsigned TabShift = 3;

  // Register reset values.
  localparam logic [CoordW-1:0] ScreenWidthRst = 12'd1920;
  localparam logic [CellW-1:0]  CharWidthRst   = 6'd8;
  localparam logic [CellW-1:0]  CharHeightRst  = 6'd16;
  localparam logic [CountW-1:0] ColumnsRst     = 8'd80;
  localparam logic [CountW-1:0] RowCountRst    = 8'd65;
  localparam logic [SpanW-1:0]  SpanRst        = SpanW'(80 * 8);
  localparam logic [SpanW-1:0]  BottomRst      = SpanW'(65 * 16);

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_WIDTH = 3'd0,
    REG_CHAR_WIDTH   = 3'd1,
    REG_CHAR_HEIGHT  = 3'd2,
    REG_COLUMNS      = 3'd3,
    REG_ROW_COUNT    = 3'd4
  } cfg_idx_e;

  // Character codes with a meaning of their own.
  localparam logic [CodeW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CodeW-1:0] CHAR_BS    = 8'h08;
  localparam logic [CodeW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CodeW-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CodeW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CodeW-1:0] CHAR_SPACE = 8'h20;

  // Draw command kinds.
  typedef enum logic {
    CMD_GLYPH = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_e;

  // One draw command.
  typedef struct packed {
    cmd_kind_e          command_kind;
    logic [CoordW-1:0]  dest_x;
    logic [CoordW-1:0]  dest_y;
    logic [CoordW-1:0]  rect_width;
    logic [CoordW-1:0]  rect_height;
    logic [FontXW-1:0]  font_x;
    logic [FontYW-1:0]  font_y;
    logic               last_of_run;
  } cmd_t;

endpackage

[hw/rtl/tcce_intf.sv]
// Valid/ready channel interfaces of the text console cursor engine.
// Depends on tcce_pkg for field widths and the command kind type.

// Character input channel.
interface tcce_char_if;
  import tcce_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

// Draw command output channel.
interface tcce_cmd_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  cmd_kind_e         command_kind;
  logic [CoordW-1:0] dest_x;
  logic [CoordW-1:0] dest_y;
  logic [CoordW-1:0] rect_width;
  logic [CoordW-1:0] rect_height;
  logic [FontXW-1:0] font_x;
  logic [FontYW-1:0] font_y;
  logic              last_of_run;

  modport source (
    output valid, output command_kind, output dest_x, output dest_y,
    output rect_width, output rect_height, output font_x, output font_y,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input command_kind, input dest_x, input dest_y,
    input rect_width, input rect_height, input font_x, input font_y,
    input last_of_run, output ready
  );
endinterface

[hw/rtl/text_console_cursor_engine_core.sv]
// Text console cursor engine core; uses tcce_pkg, tcce_intf.sv and the assertion macro header.
// A character passes through the input register and then the result buffer before its first command is valid.
// Throughput: one character per cycle while each gives at most one command and cmd_o is ready;
// a glyph with a pane clear fills the two-entry result buffer, so the next character waits for the glyph to go.
// The first character after a configuration write waits for the pane sizes to be registered.
// Reset (async, active low) loads register defaults, homes cursor and pane, empties buffers.
`include "text_console_cursor_engine_core_macros.svh"

module text_console_cursor_engine_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tcce_char_if.sink                      char_i,
  tcce_cmd_if.source                     cmd_o,
  input  logic                           cfg_we_i,
  input  logic [tcce_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcce_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tcce_pkg::*;

  // Configuration registers and the products derived from them.
  logic [CoordW-1:0] screen_width_q;
  logic [CellW-1:0]  char_width_q, char_height_q;
  logic [CountW-1:0] columns_q, row_count_q;
  logic [SpanW-1:0]  span_q, span_d, bottom_q, bottom_d;
  logic              cfg_wr_q;

  // Cursor and pane state.
  logic [PosW-1:0]   cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [CoordW-1:0] pane_left_q, pane_left_d;
  logic [PosW-1:0]   pane_right_q, pane_right_d;

  // Input register.
  logic              in_v_q, in_v_d;
  logic [CodeW-1:0]  char_q;
  logic              in_xfer, consume;

  // Result buffer: slot 0 is presented, slot 1 waits behind it.
  logic [1:0]        cnt_q, cnt_d;
  cmd_t              res0_q, res0_d, res1_q, res1_d;
  logic              out_xfer;

  // Step datapath.
  logic [8:0]        px;
  logic [SpanW-1:0]  x_sum, y_next, rnd, right_sum;
  logic [SpanW:0]    y_chk, fit_sum;
  logic              wrap, over, fits;
  logic [CoordW-1:0] new_left;
  logic [PosW-1:0]   new_right, clear_w;
  logic [CodeW-1:0]  glyph_code;
  logic [8:0]        fx_full;
  logic [10:0]       fy_full;
  logic              glyph, adv, down, moved;
  cmd_t              glyph_cmd, clear_cmd;

  // Checked conditions.
  logic              pair_ok;
  logic [PosW-1:0]   span_right;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q <= ScreenWidthRst;
      char_width_q   <= CharWidthRst;
      char_height_q  <= CharHeightRst;
      columns_q      <= ColumnsRst;
      row_count_q    <= RowCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[CoordW-1:0];
        REG_CHAR_WIDTH:   char_width_q   <= cfg_data_i[CellW-1:0];
        REG_CHAR_HEIGHT:  char_height_q  <= cfg_data_i[CellW-1:0];
        REG_COLUMNS:      columns_q      <= cfg_data_i[CountW-1:0];
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pane width and pane height in pixels, registered from the configuration registers.
  assign span_d   = SpanW'(columns_q) * SpanW'(char_width_q);
  assign bottom_d = SpanW'(row_count_q) * SpanW'(char_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q   <= SpanRst;
      bottom_q <= BottomRst;
      cfg_wr_q <= 1'b0;
    end else begin
      span_q   <= span_d;
      bottom_q <= bottom_d;
      cfg_wr_q <= cfg_we_i;
    end
  end

  // Input register handshake; a character waits while the pane sizes catch up.
  assign out_xfer     = cmd_o.valid && cmd_o.ready;
  assign consume      = in_v_q && !cfg_wr_q &&
                        ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && cmd_o.ready));
  assign char_i.ready = !in_v_q || consume;
  assign in_xfer      = char_i.valid && char_i.ready;

  always_comb begin
    in_v_d = in_v_q;
    if (in_xfer) begin
      in_v_d = 1'b1;
    end else if (consume) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_i.char_byte;
    end
  end

  // Cursor advance and right edge test.
  assign px     = (char_q == CHAR_TAB) ? (9'(char_width_q) << TabShift) : 9'(char_width_q);
  assign x_sum  = {1'b0, cursor_x_q} + SpanW'(px);
  assign wrap   = x_sum >= {1'b0, pane_right_q};

  // Row step and bottom test.
  assign y_next = {1'b0, cursor_y_q} + SpanW'(char_height_q);
  assign y_chk  = {1'b0, y_next} + (SpanW+1)'(char_height_q);
  assign over   = y_chk > {1'b0, bottom_q};

  // Next pane position: right of the current one on a 4-pixel boundary, or back to 0.
  assign fit_sum   = {2'b00, pane_right_q} + {1'b0, span_q};
  assign fits      = fit_sum <= (SpanW+1)'(screen_width_q);
  assign rnd       = {1'b0, pane_right_q} + SpanW'(3);
  assign new_left  = fits ? {rnd[CoordW-1:2], 2'b00} : '0;
  assign right_sum = SpanW'(new_left) + span_q;
  assign new_right = right_sum[PosW-1:0];
  assign clear_w   = new_right - PosW'(new_left);

  // Font sheet source; codes 1 to 32 other than the control codes are drawn as a space.
  assign glyph_code = (char_q <= CHAR_SPACE) ? CHAR_SPACE : char_q;
  assign fx_full    = 9'(char_width_q) * 9'(glyph_code[7:5]);
  assign fy_full    = 11'(char_height_q) * 11'(glyph_code[4:0]);

  // Control code decode and the cursor and pane update.
  always_comb begin
    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    pane_left_d  = pane_left_q;
    pane_right_d = pane_right_q;
    glyph        = 1'b0;
    adv          = 1'b0;
    down         = 1'b0;
    moved        = 1'b0;
    unique case (char_q)
      CHAR_NUL: ;
      CHAR_CR: cursor_x_d = PosW'(pane_left_q);
      CHAR_LF: down = 1'b1;
      CHAR_TAB: adv = 1'b1;
      CHAR_BS: begin
        if (cursor_x_q >= PosW'(char_width_q)) begin
          cursor_x_d = cursor_x_q - PosW'(char_width_q);
        end else if (cursor_y_q > PosW'(char_height_q)) begin
          cursor_x_d = pane_right_q - PosW'(char_width_q);
          cursor_y_d = cursor_y_q - PosW'(char_height_q);
        end
      end
      default: begin
        glyph = 1'b1;
        adv   = 1'b1;
      end
    endcase
    if (adv) begin
      if (wrap) begin
        cursor_x_d = PosW'(pane_left_q);
        down       = 1'b1;
      end else begin
        cursor_x_d = x_sum[PosW-1:0];
      end
    end
    if (down) begin
      if (over) begin
        moved        = 1'b1;
        pane_left_d  = new_left;
        pane_right_d = new_right;
        cursor_x_d   = PosW'(new_left);
        cursor_y_d   = '0;
      end else begin
        cursor_y_d = y_next[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      pane_left_q  <= '0;
      pane_right_q <= SpanRst[PosW-1:0];
    end else if (consume) begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      pane_left_q  <= pane_left_d;
      pane_right_q <= pane_right_d;
    end
  end

  // Commands built from the state before the update (glyph) and after it (clear).
  always_comb begin
    glyph_cmd.command_kind = CMD_GLYPH;
    glyph_cmd.dest_x       = cursor_x_q[CoordW-1:0];
    glyph_cmd.dest_y       = cursor_y_q[CoordW-1:0];
    glyph_cmd.rect_width   = CoordW'(char_width_q);
    glyph_cmd.rect_height  = CoordW'(char_height_q);
    glyph_cmd.font_x       = fx_full[FontXW-1:0];
    glyph_cmd.font_y       = fy_full[FontYW-1:0];
    glyph_cmd.last_of_run  = !moved;

    clear_cmd.command_kind = CMD_CLEAR;
    clear_cmd.dest_x       = new_left;
    clear_cmd.dest_y       = '0;
    clear_cmd.rect_width   = clear_w[CoordW-1:0];
    clear_cmd.rect_height  = bottom_q[CoordW-1:0];
    clear_cmd.font_x       = '0;
    clear_cmd.font_y       = '0;
    clear_cmd.last_of_run  = 1'b1;
  end

  // Result buffer: drain on output transfers, refill when a character is consumed.
  always_comb begin
    cnt_d  = cnt_q;
    res0_d = res0_q;
    res1_d = res1_q;
    if (out_xfer) begin
      if (cnt_q == 2'd2) begin
        res0_d = res1_q;
        cnt_d  = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
    if (consume) begin
      cnt_d  = {glyph & moved, glyph ^ moved};
      res0_d = glyph ? glyph_cmd : clear_cmd;
      res1_d = clear_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  // Output channel.
  assign cmd_o.valid        = cnt_q != 2'd0;
  assign cmd_o.command_kind = res0_q.command_kind;
  assign cmd_o.dest_x       = res0_q.dest_x;
  assign cmd_o.dest_y       = res0_q.dest_y;
  assign cmd_o.rect_width   = res0_q.rect_width;
  assign cmd_o.rect_height  = res0_q.rect_height;
  assign cmd_o.font_x       = res0_q.font_x;
  assign cmd_o.font_y       = res0_q.font_y;
  assign cmd_o.last_of_run  = res0_q.last_of_run;

  // Conditions used by the checks below.
  assign pair_ok    = (res0_q.command_kind == CMD_GLYPH) &&
                      (res1_q.command_kind == CMD_CLEAR) && !res0_q.last_of_run;
  assign span_right = PosW'(SpanW'(pane_left_q) + span_q);

  // The buffer never holds more than a glyph and a clear.
  `TCCE_ASSERT(a_cnt_range, cnt_q != 2'd3, "result buffer count out of range")
  // A full buffer always holds a glyph that is not last, followed by a clear.
  `TCCE_ASSERT(a_pair_order, (cnt_q == 2'd2) |-> pair_ok, "bad result pair")
  // After a pane move the pane spans exactly one pane width.
  `TCCE_ASSERT_NEXT(a_pane_span, consume && moved, pane_right_q == span_right, "bad pane span")

endmodule
